@@ rtl/svfbrb_pkg.sv @@
`timescale 1ns / 1ps

package svfbrb_pkg;

  // Bank size and derived index widths.
  localparam int MAX_MODES = 32;
  localparam int MIN_MODES = 4;
  localparam int MODE_W    = $clog2(MAX_MODES);
  localparam int CNT_W     = $clog2(MAX_MODES + 1);
  localparam int CFG_W     = 6;
  localparam int CMP_W     = (CFG_W > CNT_W) ? CFG_W : CNT_W;

  // Fixed-point formats.
  localparam int SAMPLE_W  = 24;
  localparam int COEF_W    = 17;
  localparam int COEF_FRAC = 16;
  localparam int INT_W     = 48;
  localparam int WIDE_W    = INT_W + 2;
  localparam int ACC_W     = INT_W + $clog2(MAX_MODES) + 1;
  localparam int DIV_CNT_W = $clog2(ACC_W + 1);

  localparam logic [COEF_W-1:0] COEF_ONE = COEF_W'(1 << COEF_FRAC);

  // Item command codes.
  typedef enum logic [1:0] {
    CMD_PROCESS = 2'd0,
    CMD_WRITE   = 2'd1,
    CMD_CLEAR   = 2'd2
  } cmd_e;

  // Controller states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_LD,
    ST_M2,
    ST_M3,
    ST_M4,
    ST_M5,
    ST_M6,
    ST_M7,
    ST_DIVGO,
    ST_DIV,
    ST_OUT
  } st_e;

  // Datapath operations, one per cycle.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_START,
    OP_READ,
    OP_LD,
    OP_M2,
    OP_M3,
    OP_M4,
    OP_M5,
    OP_M6,
    OP_M7,
    OP_DIVGO,
    OP_FIN
  } dp_op_e;

  typedef struct packed {
    dp_op_e              op;
    logic [MODE_W-1:0]   mode;
    logic [CNT_W-1:0]    count;
    logic                wr_coef;
    logic                clr_integ;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_done;
  } dp_stat_t;

endpackage

@@ rtl/svfbrb_cmul.sv @@
`timescale 1ns / 1ps

// Coefficient times 48-bit value, rounded Q.16 product. Two pipeline
// stages: split partial products, then recombine and round.
module svfbrb_cmul import svfbrb_pkg::*; (
  input  logic                     clk_i,
  input  logic [COEF_W-1:0]        coef_i,
  input  logic signed [INT_W-1:0]  val_i,
  output logic signed [INT_W-1:0]  res_o
);

  localparam int HALF  = INT_W / 2;
  localparam int LO_W  = COEF_W + HALF;
  localparam int HI_W  = COEF_W + 1 + (INT_W - HALF);
  localparam int SUM_W = COEF_W + INT_W + 2;

  logic [COEF_W-1:0]        cc;
  logic [LO_W-1:0]          pp_lo_q;
  logic signed [HI_W-1:0]   pp_hi_q;
  logic signed [SUM_W-1:0]  hi_ext;
  logic signed [SUM_W-1:0]  lo_ext;
  logic signed [SUM_W-1:0]  sum;
  logic signed [INT_W-1:0]  res_q;

  // Coefficients above one act as one.
  assign cc = (coef_i > COEF_ONE) ? COEF_ONE : coef_i;

  // Stage one: unsigned low half and signed high half.
  always_ff @(posedge clk_i) begin
    pp_lo_q <= cc * val_i[HALF-1:0];
    pp_hi_q <= $signed({1'b0, cc}) * $signed(val_i[INT_W-1:HALF]);
  end

  // Stage two: recombine, add half an LSB and take the floor.
  assign hi_ext = SUM_W'(pp_hi_q);
  assign lo_ext = $signed(SUM_W'(pp_lo_q));
  assign sum    = (hi_ext <<< HALF) + lo_ext + SUM_W'(1 << (COEF_FRAC - 1));

  always_ff @(posedge clk_i) begin
    res_q <= sum[INT_W+COEF_FRAC-1:COEF_FRAC];
  end

  assign res_o = res_q;

endmodule

@@ rtl/svfbrb_div.sv @@
`timescale 1ns / 1ps

// Signed accumulator divided by the mode count, truncated toward zero.
// Restoring division, one quotient bit per cycle.
module svfbrb_div import svfbrb_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic signed [ACC_W-1:0]  dividend_i,
  input  logic [CNT_W-1:0]         divisor_i,
  output logic                     done_o,
  output logic [ACC_W-1:0]         quot_o,
  output logic                     neg_o
);

  logic                  busy_q;
  logic                  done_q;
  logic [DIV_CNT_W-1:0]  cnt_q;
  logic [CNT_W-1:0]      div_q;
  logic [CNT_W-1:0]      rem_q;
  logic [ACC_W-1:0]      quo_q;
  logic                  neg_q;
  logic [CNT_W:0]        trial;
  logic                  ge;
  logic [CNT_W:0]        diff;
  logic [ACC_W-1:0]      mag;

  // Magnitude of the dividend.
  assign mag = dividend_i[ACC_W-1] ? ACC_W'(-dividend_i) : ACC_W'(dividend_i);

  // One restoring step.
  assign trial = {rem_q, quo_q[ACC_W-1]};
  assign ge    = (trial >= {1'b0, div_q});
  assign diff  = trial - {1'b0, div_q};

  // Control: busy flag, step counter and done pulse.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + DIV_CNT_W'(1);
        if (cnt_q == DIV_CNT_W'(ACC_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Operand and partial result registers.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      div_q <= divisor_i;
      rem_q <= '0;
      quo_q <= mag;
      neg_q <= dividend_i[ACC_W-1];
    end else if (busy_q) begin
      rem_q <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
      quo_q <= {quo_q[ACC_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
  assign neg_o  = neg_q;

endmodule

@@ rtl/svfbrb_dp.sv @@
`timescale 1ns / 1ps

// Datapath: coefficient and integrator memories, the shared multiplier,
// the filter update registers, the accumulator, divider and output stage.
module svfbrb_dp import svfbrb_pkg::*; (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  ctrl_cmd_t                   cmd_i,
  output dp_stat_t                    stat_o,
  input  logic signed [SAMPLE_W-1:0]  sample_in_i,
  input  logic [4:0]                  mode_index_i,
  input  logic [COEF_W-1:0]           coef_a1_i,
  input  logic [COEF_W-1:0]           coef_a2_i,
  input  logic [COEF_W-1:0]           coef_a3_i,
  input  logic [COEF_W-1:0]           mode_gain_i,
  output logic signed [SAMPLE_W-1:0]  sample_out_o,
  output logic                        saturated_o
);

  // Top bits not all equal means the value leaves the 48-bit range.
  function automatic logic ovf48(input logic signed [WIDE_W-1:0] v);
    logic [WIDE_W-INT_W:0] top;
    top = v[WIDE_W-1:INT_W-1];
    return !((&top) || (~|top));
  endfunction

  function automatic logic signed [INT_W-1:0] sat48(input logic signed [WIDE_W-1:0] v);
    if (ovf48(v)) begin
      return v[WIDE_W-1] ? {1'b1, {(INT_W-1){1'b0}}} : {1'b0, {(INT_W-1){1'b1}}};
    end
    return v[INT_W-1:0];
  endfunction

  logic [2*INT_W-1:0]   integ_mem [MAX_MODES];
  logic [4*COEF_W-1:0]  coef_mem  [MAX_MODES];
  logic [MAX_MODES-1:0] ivalid_q;
  logic [MAX_MODES-1:0] cvalid_q;

  logic [2*INT_W-1:0]   integ_rd_q;
  logic [4*COEF_W-1:0]  coef_rd_q;
  logic                 ivld_rd_q;
  logic                 cvld_rd_q;

  logic signed [SAMPLE_W-1:0] x_q;
  logic signed [INT_W-1:0]    ic1, ic2;
  logic [COEF_W-1:0]          a1, a2, a3, gain;
  logic signed [INT_W-1:0]    v3_q, v1p_q, v1_q, v2_q, ic1n_q;
  logic signed [INT_W:0]      v2p_q;
  logic signed [ACC_W-1:0]    acc_q;
  logic                       clip_q;
  logic signed [SAMPLE_W-1:0] out_q;
  logic                       sat_out_q;

  logic [COEF_W-1:0]          mul_coef;
  logic signed [INT_W-1:0]    mul_val;
  logic signed [INT_W-1:0]    mul_res;

  logic signed [WIDE_W-1:0]   w_v3, w_v1, w_v2, w_ic1n, w_ic2n;
  logic signed [INT_W-1:0]    ic2n;
  logic                       clip_now;

  logic                       div_done;
  logic [ACC_W-1:0]           quot;
  logic                       quot_neg;
  logic                       big;
  logic signed [SAMPLE_W-1:0] y;
  logic                       wr_ok;

  // Entries never written read as zero.
  assign ic1  = ivld_rd_q ? $signed(integ_rd_q[2*INT_W-1:INT_W]) : '0;
  assign ic2  = ivld_rd_q ? $signed(integ_rd_q[INT_W-1:0]) : '0;
  assign a1   = cvld_rd_q ? coef_rd_q[4*COEF_W-1:3*COEF_W] : '0;
  assign a2   = cvld_rd_q ? coef_rd_q[3*COEF_W-1:2*COEF_W] : '0;
  assign a3   = cvld_rd_q ? coef_rd_q[2*COEF_W-1:COEF_W] : '0;
  assign gain = cvld_rd_q ? coef_rd_q[COEF_W-1:0] : '0;

  assign wr_ok = (32'(mode_index_i) < 32'(MAX_MODES));

  // Coefficient memory: written by write items, read once per mode.
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_coef && wr_ok) begin
      coef_mem[MODE_W'(mode_index_i)] <= {coef_a1_i, coef_a2_i, coef_a3_i, mode_gain_i};
    end
    if (cmd_i.op == OP_READ) begin
      coef_rd_q <= coef_mem[cmd_i.mode];
    end
  end

  // Integrator memory: written back at the end of each mode.
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_M7) begin
      integ_mem[cmd_i.mode] <= {ic1n_q, ic2n};
    end
    if (cmd_i.op == OP_READ) begin
      integ_rd_q <= integ_mem[cmd_i.mode];
    end
  end

  // Valid bits: reset clears both, a clear item clears the integrators.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ivalid_q  <= '0;
      cvalid_q  <= '0;
      ivld_rd_q <= 1'b0;
      cvld_rd_q <= 1'b0;
    end else begin
      if (cmd_i.wr_coef && wr_ok) begin
        cvalid_q[MODE_W'(mode_index_i)] <= 1'b1;
      end
      if (cmd_i.clr_integ) begin
        ivalid_q <= '0;
      end else if (cmd_i.op == OP_M7) begin
        ivalid_q[cmd_i.mode] <= 1'b1;
      end
      if (cmd_i.op == OP_READ) begin
        ivld_rd_q <= ivalid_q[cmd_i.mode];
        cvld_rd_q <= cvalid_q[cmd_i.mode];
      end
    end
  end

  // Multiplier operand selection per step.
  always_comb begin
    mul_coef = '0;
    mul_val  = '0;
    case (cmd_i.op)
      OP_LD: begin
        mul_coef = a1;
        mul_val  = ic1;
      end
      OP_M2: begin
        mul_coef = a2;
        mul_val  = v3_q;
      end
      OP_M3: begin
        mul_coef = a2;
        mul_val  = ic1;
      end
      OP_M4: begin
        mul_coef = a3;
        mul_val  = v3_q;
      end
      OP_M5: begin
        mul_coef = gain;
        mul_val  = v1_q;
      end
      default: begin
        mul_coef = '0;
        mul_val  = '0;
      end
    endcase
  end

  svfbrb_cmul u_cmul (
    .clk_i  (clk_i),
    .coef_i (mul_coef),
    .val_i  (mul_val),
    .res_o  (mul_res)
  );

  // Filter update sums before saturation.
  assign w_v3   = WIDE_W'(x_q) - WIDE_W'(ic2);
  assign w_v1   = WIDE_W'(v1p_q) + WIDE_W'(mul_res);
  assign w_v2   = WIDE_W'(v2p_q) + WIDE_W'(mul_res);
  assign w_ic1n = (WIDE_W'(v1_q) <<< 1) - WIDE_W'(ic1);
  assign w_ic2n = (WIDE_W'(v2_q) <<< 1) - WIDE_W'(ic2);
  assign ic2n   = sat48(w_ic2n);

  // Clip detection for the saturation taken in this step.
  always_comb begin
    case (cmd_i.op)
      OP_LD:   clip_now = ovf48(w_v3);
      OP_M4:   clip_now = ovf48(w_v1);
      OP_M6:   clip_now = ovf48(w_v2) || ovf48(w_ic1n);
      OP_M7:   clip_now = ovf48(w_ic2n);
      OP_FIN:  clip_now = big;
      default: clip_now = 1'b0;
    endcase
  end

  // Per-mode working registers and the sample accumulator.
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_START: begin
        x_q   <= sample_in_i;
        acc_q <= '0;
      end
      OP_LD:  v3_q  <= sat48(w_v3);
      OP_M3:  v1p_q <= mul_res;
      OP_M4:  v1_q  <= sat48(w_v1);
      OP_M5:  v2p_q <= (INT_W+1)'(ic2) + (INT_W+1)'(mul_res);
      OP_M6: begin
        v2_q   <= sat48(w_v2);
        ic1n_q <= sat48(w_ic1n);
      end
      OP_M7:  acc_q <= acc_q + ACC_W'(mul_res);
      default: begin
      end
    endcase
  end

  // Sticky clip flag over one sample.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clip_q <= 1'b0;
    end else if (cmd_i.op == OP_START) begin
      clip_q <= 1'b0;
    end else if (clip_now) begin
      clip_q <= 1'b1;
    end
  end

  svfbrb_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.op == OP_DIVGO),
    .dividend_i (acc_q),
    .divisor_i  (cmd_i.count),
    .done_o     (div_done),
    .quot_o     (quot),
    .neg_o      (quot_neg)
  );

  // Clamp the quotient to the 24-bit sample range.
  always_comb begin
    if (quot_neg) begin
      big = (|quot[ACC_W-1:SAMPLE_W]) || (quot[SAMPLE_W-1] && (|quot[SAMPLE_W-2:0]));
      y   = big ? {1'b1, {(SAMPLE_W-1){1'b0}}} : $signed(-quot[SAMPLE_W-1:0]);
    end else begin
      big = |quot[ACC_W-1:SAMPLE_W-1];
      y   = big ? {1'b0, {(SAMPLE_W-1){1'b1}}} : $signed(quot[SAMPLE_W-1:0]);
    end
  end

  // Output register, loaded when the result item is formed.
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_FIN) begin
      out_q     <= y;
      sat_out_q <= clip_q || big;
    end
  end

  assign stat_o.div_done = div_done;
  assign sample_out_o    = out_q;
  assign saturated_o     = sat_out_q;

endmodule

@@ rtl/svfbrb_ctrl.sv @@
`timescale 1ns / 1ps

// Controller: item handshake, mode count register, step sequencer and
// result valid flag.
module svfbrb_ctrl import svfbrb_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        command_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  logic              cfg_we_i,
  input  logic [CFG_W-1:0]  cfg_data_i,
  output ctrl_cmd_t         cmd_o,
  input  dp_stat_t          stat_i
);

  st_e                state_q, state_d;
  logic [MODE_W-1:0]  mode_q, mode_d;
  logic [CFG_W-1:0]   active_q;
  logic               out_valid_q, out_valid_d;
  logic [CMP_W-1:0]   act_w;
  logic [CNT_W-1:0]   count;
  logic               last_mode;
  logic               accept;

  // Mode count clamped to the supported range.
  assign act_w = CMP_W'(active_q);
  always_comb begin
    if (act_w < CMP_W'(MIN_MODES)) begin
      count = CNT_W'(MIN_MODES);
    end else if (act_w > CMP_W'(MAX_MODES)) begin
      count = CNT_W'(MAX_MODES);
    end else begin
      count = CNT_W'(act_w);
    end
  end

  assign last_mode = (CNT_W'(mode_q) == (count - CNT_W'(1)));
  // The block takes an item only while idle.
  assign accept    = in_valid_i && (state_q == ST_IDLE);

  // State, mode counter, configuration and output valid registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mode_q      <= '0;
      active_q    <= CFG_W'(MIN_MODES);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        active_q <= cfg_data_i;
      end
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_d         = state_q;
    mode_d          = mode_q;
    out_valid_d     = out_valid_q && !out_ready_i;
    in_ready_o      = 1'b0;
    cmd_o.op        = OP_NONE;
    cmd_o.mode      = mode_q;
    cmd_o.count     = count;
    cmd_o.wr_coef   = 1'b0;
    cmd_o.clr_integ = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (accept) begin
          case (command_i)
            CMD_PROCESS: begin
              cmd_o.op = OP_START;
              mode_d   = '0;
              state_d  = ST_READ;
            end
            CMD_WRITE: cmd_o.wr_coef   = 1'b1;
            CMD_CLEAR: cmd_o.clr_integ = 1'b1;
            default: begin
            end
          endcase
        end
      end
      ST_READ: begin
        cmd_o.op = OP_READ;
        state_d  = ST_LD;
      end
      ST_LD: begin
        cmd_o.op = OP_LD;
        state_d  = ST_M2;
      end
      ST_M2: begin
        cmd_o.op = OP_M2;
        state_d  = ST_M3;
      end
      ST_M3: begin
        cmd_o.op = OP_M3;
        state_d  = ST_M4;
      end
      ST_M4: begin
        cmd_o.op = OP_M4;
        state_d  = ST_M5;
      end
      ST_M5: begin
        cmd_o.op = OP_M5;
        state_d  = ST_M6;
      end
      ST_M6: begin
        cmd_o.op = OP_M6;
        state_d  = ST_M7;
      end
      ST_M7: begin
        cmd_o.op = OP_M7;
        if (last_mode) begin
          state_d = ST_DIVGO;
        end else begin
          mode_d  = mode_q + MODE_W'(1);
          state_d = ST_READ;
        end
      end
      ST_DIVGO: begin
        cmd_o.op = OP_DIVGO;
        state_d  = ST_DIV;
      end
      ST_DIV: begin
        if (stat_i.div_done) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        // Wait for the output register to be free.
        if (!out_valid_q || out_ready_i) begin
          cmd_o.op    = OP_FIN;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ rtl/svf_bandpass_resonator_bank_core.sv @@
`timescale 1ns / 1ps

// Bank of state-variable bandpass resonators. A process item runs its
// sample through every active mode, one mode at a time, and yields one
// result item with the averaged, saturated output and a clip flag. Write and
// clear items give no result and can follow each other in consecutive
// cycles. A process item keeps the block busy through all N active modes
// (4 to 32) and the division by N: each mode takes eight steps through
// the single shared coefficient multiplier and the one integrator memory
// port, and the division is bit-serial, one quotient bit per cycle over
// the 54-bit accumulator. A finished result waits in the output register
// while the next item is accepted.
module svf_bandpass_resonator_bank_core import svfbrb_pkg::*; (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [1:0]                  command_i,
  input  logic signed [SAMPLE_W-1:0]  sample_in_i,
  input  logic [4:0]                  mode_index_i,
  input  logic [COEF_W-1:0]           coef_a1_i,
  input  logic [COEF_W-1:0]           coef_a2_i,
  input  logic [COEF_W-1:0]           coef_a3_i,
  input  logic [COEF_W-1:0]           mode_gain_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic signed [SAMPLE_W-1:0]  sample_out_o,
  output logic                        saturated_o,
  input  logic                        cfg_we_i,
  input  logic [CFG_W-1:0]            cfg_data_i
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  svfbrb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .command_i   (command_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  svfbrb_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .sample_in_i  (sample_in_i),
    .mode_index_i (mode_index_i),
    .coef_a1_i    (coef_a1_i),
    .coef_a2_i    (coef_a2_i),
    .coef_a3_i    (coef_a3_i),
    .mode_gain_i  (mode_gain_i),
    .sample_out_o (sample_out_o),
    .saturated_o  (saturated_o)
  );

  // A process item makes the block busy in the next cycle.
  a_process_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && command_i == CMD_PROCESS) |=> !in_ready_o)
    else $error("block still ready after a process item");

  // Write and clear items leave the block ready.
  a_cmd_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && command_i != CMD_PROCESS) |=> in_ready_o)
    else $error("block busy after a write or clear item");

  // A result appears only at the end of a process item.
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result item raised while idle");

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps

module tb import svfbrb_pkg::*;;

  localparam longint LIM48 = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint LIM24 = 64'sh0000_0000_007F_FFFF;
  // Slowest process item per the block's own latency, plus some margin.
  localparam int SETTLE_CYCLES = 8 * MAX_MODES + 58 + 20;
  localparam int LONG_HOLD = 600;
  localparam int RANDOM_ITEMS_END = 730;
  localparam int MAX_REPORTS = 50;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef struct {
    logic [SAMPLE_W-1:0] sample;
    logic                clip;
  } bank_result_t;

  typedef enum int {
    RX_OPEN,
    RX_COIN,
    RX_SPARSE,
    RX_PERIODIC
  } rx_pattern_e;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       in_valid_i = 1'b0;
  logic                       in_ready_o;
  logic [1:0]                 command_i = '0;
  logic signed [SAMPLE_W-1:0] sample_in_i = '0;
  logic [4:0]                 mode_index_i = '0;
  logic [COEF_W-1:0]          coef_a1_i = '0;
  logic [COEF_W-1:0]          coef_a2_i = '0;
  logic [COEF_W-1:0]          coef_a3_i = '0;
  logic [COEF_W-1:0]          mode_gain_i = '0;
  logic                       out_valid_o;
  logic                       out_ready_i = 1'b0;
  logic signed [SAMPLE_W-1:0] sample_out_o;
  logic                       saturated_o;
  logic                       cfg_we_i = 1'b0;
  logic [CFG_W-1:0]           cfg_data_i = '0;

  svf_bandpass_resonator_bank_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .command_i    (command_i),
    .sample_in_i  (sample_in_i),
    .mode_index_i (mode_index_i),
    .coef_a1_i    (coef_a1_i),
    .coef_a2_i    (coef_a2_i),
    .coef_a3_i    (coef_a3_i),
    .mode_gain_i  (mode_gain_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .sample_out_o (sample_out_o),
    .saturated_o  (saturated_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_data_i   (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Local copy of the bank: integrators, coefficient store and mode count.
  longint            first_integ [MAX_MODES];
  longint            second_integ [MAX_MODES];
  logic [COEF_W-1:0] a1_store [MAX_MODES];
  logic [COEF_W-1:0] a2_store [MAX_MODES];
  logic [COEF_W-1:0] a3_store [MAX_MODES];
  logic [COEF_W-1:0] gain_store [MAX_MODES];
  logic [CFG_W-1:0]  bank_size = CFG_W'(MIN_MODES);
  bit                clip_seen;

  bank_result_t expected_outputs[$];
  int error_count = 0;

  // Sender and receiver pacing state.
  int burst_left = 0;
  bit gaps_on = 1'b1;
  int items_sent = 0;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;
  int stall_left = 0;
  rx_pattern_e stall_kind = RX_OPEN;

  initial begin
    for (int i = 0; i < MAX_MODES; i++) begin
      first_integ[i] = 0;
      second_integ[i] = 0;
      a1_store[i] = '0;
      a2_store[i] = '0;
      a3_store[i] = '0;
      gain_store[i] = '0;
    end
  end

  task automatic report_mismatch(input string what);
    error_count++;
    // Keep the log short when the block is badly broken.
    if (error_count <= MAX_REPORTS) begin
      $display("mismatch at %0t ns: %s", $time, what);
    end
  endtask

  // Clamp to the two's complement range -lim-1 to lim and note any clip.
  function automatic longint clip_to(input longint v, input longint lim);
    if (v > lim) begin
      clip_seen = 1'b1;
      return lim;
    end
    if (v < -lim - 1) begin
      clip_seen = 1'b1;
      return -lim - 1;
    end
    return v;
  endfunction

  // Coefficient times value, the coefficient limited to one, rounded half up.
  function automatic longint scale_by(input logic [COEF_W-1:0] c, input longint v);
    longint cc;
    cc = (c > COEF_ONE) ? longint'(COEF_ONE) : longint'(c);
    return (cc * v + (64'sd1 <<< (COEF_FRAC - 1))) >>> COEF_FRAC;
  endfunction

  // Runs one sample through every active mode and returns the averaged output.
  function automatic bank_result_t bank_output_for(input logic signed [SAMPLE_W-1:0] s);
    longint x, ic1, ic2, v1, v2, v3, acc, n;
    bank_result_t r;
    x = longint'(s);
    n = bank_size;
    if (n < MIN_MODES) n = MIN_MODES;
    if (n > MAX_MODES) n = MAX_MODES;
    acc = 0;
    clip_seen = 1'b0;
    for (int i = 0; i < n; i++) begin
      ic1 = first_integ[i];
      ic2 = second_integ[i];
      v3 = clip_to(x - ic2, LIM48);
      v1 = clip_to(scale_by(a1_store[i], ic1) + scale_by(a2_store[i], v3), LIM48);
      v2 = clip_to(ic2 + scale_by(a2_store[i], ic1) + scale_by(a3_store[i], v3), LIM48);
      first_integ[i] = clip_to(2 * v1 - ic1, LIM48);
      second_integ[i] = clip_to(2 * v2 - ic2, LIM48);
      acc += scale_by(gain_store[i], v1);
    end
    r.sample = SAMPLE_W'(clip_to(acc / n, LIM24));
    r.clip = clip_seen;
    return r;
  endfunction

  // Applies one accepted item to the local bank copy.
  task automatic bank_accept_item(input logic [1:0] cmd, input logic [SAMPLE_W-1:0] s,
                                  input logic [4:0] idx, input logic [COEF_W-1:0] a1,
                                  input logic [COEF_W-1:0] a2, input logic [COEF_W-1:0] a3,
                                  input logic [COEF_W-1:0] g);
    case (cmd)
      CMD_PROCESS: begin
        expected_outputs.push_back(bank_output_for(s));
      end
      CMD_WRITE: begin
        a1_store[idx] = a1;
        a2_store[idx] = a2;
        a3_store[idx] = a3;
        gain_store[idx] = g;
      end
      CMD_CLEAR: begin
        for (int i = 0; i < MAX_MODES; i++) begin
          first_integ[i] = 0;
          second_integ[i] = 0;
        end
      end
      default: ;
    endcase
  endtask

  // Offers one item, idling between bursts, and waits for it to be taken.
  task automatic send_item(input logic [1:0] cmd, input logic [SAMPLE_W-1:0] s,
                           input logic [4:0] idx, input logic [COEF_W-1:0] a1,
                           input logic [COEF_W-1:0] a2, input logic [COEF_W-1:0] a3,
                           input logic [COEF_W-1:0] g);
    int gap;
    if (gaps_on && burst_left <= 0) begin
      gap = $urandom_range(1, 14);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
      burst_left = $urandom_range(1, 12);
    end
    in_valid_i <= 1'b1;
    command_i <= cmd;
    sample_in_i <= s;
    mode_index_i <= idx;
    coef_a1_i <= a1;
    coef_a2_i <= a2;
    coef_a3_i <= a3;
    mode_gain_i <= g;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    bank_accept_item(cmd, s, idx, a1, a2, a3, g);
    burst_left--;
    items_sent++;
  endtask

  task automatic send_sample(input logic [SAMPLE_W-1:0] s);
    send_item(CMD_PROCESS, s, 5'($urandom), COEF_W'($urandom), COEF_W'($urandom),
              COEF_W'($urandom), COEF_W'($urandom));
  endtask

  task automatic send_coefs(input logic [4:0] idx, input logic [COEF_W-1:0] a1,
                            input logic [COEF_W-1:0] a2, input logic [COEF_W-1:0] a3,
                            input logic [COEF_W-1:0] g);
    send_item(CMD_WRITE, SAMPLE_W'($urandom), idx, a1, a2, a3, g);
  endtask

  task automatic send_clear();
    send_item(CMD_CLEAR, SAMPLE_W'($urandom), 5'($urandom), COEF_W'($urandom),
              COEF_W'($urandom), COEF_W'($urandom), COEF_W'($urandom));
  endtask

  task automatic send_unused();
    send_item(CMD_UNUSED, SAMPLE_W'($urandom), 5'($urandom), COEF_W'($urandom),
              COEF_W'($urandom), COEF_W'($urandom), COEF_W'($urandom));
  endtask

  task automatic release_sender();
    in_valid_i <= 1'b0;
    burst_left = 0;
  endtask

  task automatic wait_drained();
    release_sender();
    while (expected_outputs.size() != 0) @(posedge clk_i);
  endtask

  // Mode count changes only once the bank has finished all pending work.
  task automatic set_modes(input int value);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_data_i <= CFG_W'(value);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    bank_size = CFG_W'(value);
  endtask

  // Coefficients of a stable resonator from a random tuning and damping.
  task automatic make_resonator(output logic [COEF_W-1:0] a1, output logic [COEF_W-1:0] a2,
                                output logic [COEF_W-1:0] a3, output logic [COEF_W-1:0] g);
    real tune, damp, d;
    tune = $urandom_range(5, 3000) / 1000.0;
    damp = $urandom_range(2, 2000) / 1000.0;
    d = 1.0 / (1.0 + tune * (tune + damp));
    a1 = COEF_W'($rtoi(d * 65536.0 + 0.5));
    a2 = COEF_W'($rtoi(tune * d * 65536.0 + 0.5));
    a3 = COEF_W'($rtoi(tune * tune * d * 65536.0 + 0.5));
    g = COEF_W'($urandom_range(0, 65536));
  endtask

  function automatic logic [SAMPLE_W-1:0] random_sample();
    case ($urandom_range(0, 5))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2, 3: return SAMPLE_W'($urandom);
      default: return SAMPLE_W'($urandom_range(0, 131071) - 65536);
    endcase
  endfunction

  // Silent bank straight out of reset: outputs stay zero.
  task automatic test_silent_bank();
    send_sample(24'h7FFFFF);
    send_sample(24'h800000);
    send_unused();
    send_sample(24'h000000);
  endtask

  // Coefficients at one, above one and zero, full-scale samples, clears.
  task automatic test_directed_extremes();
    send_coefs(5'd0, COEF_ONE, COEF_ONE, COEF_ONE, COEF_ONE);
    send_coefs(5'd1, '1, '1, '1, '1);
    send_coefs(5'd2, 17'd60000, 17'd3000, 17'd150, 17'd32768);
    send_coefs(5'd3, '0, '0, '0, COEF_ONE);
    send_sample(24'h7FFFFF);
    send_sample(24'h7FFFFF);
    send_sample(24'h800000);
    send_sample(24'h800000);
    send_sample(24'h000000);
    send_clear();
    send_sample(24'h7FFFFF);
    send_item(CMD_UNUSED, 24'h7FFFFF, '1, '1, '1, '1, '1);
    // A rewrite must leave the integrators of that mode alone.
    send_coefs(5'd0, 17'd65000, 17'd1200, 17'd20, 17'd65536);
    send_sample(24'h000001);
    send_sample(24'hFFFFFF);
    send_clear();
    send_clear();
    send_sample(24'h800000);
  endtask

  // Register values outside the legal mode range.
  task automatic test_mode_count_range();
    logic [COEF_W-1:0] a1, a2, a3, g;
    make_resonator(a1, a2, a3, g);
    send_coefs(5'd31, a1, a2, a3, g);
    set_modes(0);
    send_sample(random_sample());
    set_modes(3);
    send_sample(random_sample());
    set_modes(33);
    send_sample(random_sample());
    set_modes(63);
    send_sample(random_sample());
  endtask

  // The receiver holds off long enough for the bank to stall its input.
  task automatic test_backpressure();
    set_modes(8);
    gaps_on = 1'b0;
    hold_requests++;
    repeat (12) send_sample(random_sample());
    gaps_on = 1'b1;
  endtask

  // Random phases: program a bank of resonators, then stream mostly samples.
  task automatic test_random_bank();
    int modes, live, pick;
    logic [COEF_W-1:0] a1, a2, a3, g;
    while (items_sent < RANDOM_ITEMS_END) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) modes = $urandom_range(4, 8);
      else if (pick < 8) modes = $urandom_range(9, 16);
      else if (pick == 8) modes = MAX_MODES;
      else modes = $urandom_range(0, 63);
      set_modes(modes);
      live = (modes < MIN_MODES) ? MIN_MODES : ((modes > MAX_MODES) ? MAX_MODES : modes);
      gaps_on = ($urandom_range(0, 3) != 0);
      for (int m = 0; m < live; m++) begin
        make_resonator(a1, a2, a3, g);
        send_coefs(5'(m), a1, a2, a3, g);
      end
      if ($urandom_range(0, 1) == 0) send_clear();
      repeat ($urandom_range(30, 60)) begin
        pick = $urandom_range(0, 99);
        if (pick < 78) begin
          send_sample(random_sample());
        end else if (pick < 88) begin
          make_resonator(a1, a2, a3, g);
          send_coefs(5'($urandom_range(0, live - 1)), a1, a2, a3, g);
        end else if (pick < 93) begin
          send_coefs(5'($urandom), COEF_W'($urandom_range(0, 131071)),
                     COEF_W'($urandom_range(0, 131071)), COEF_W'($urandom_range(0, 131071)),
                     COEF_W'($urandom_range(0, 131071)));
        end else if (pick < 97) begin
          send_clear();
        end else begin
          send_unused();
        end
      end
    end
    gaps_on = 1'b1;
  endtask

  // The sender stops until every result is back, then carries on.
  task automatic test_drain_pause();
    repeat (10) send_sample(random_sample());
    wait_drained();
    repeat (10) send_sample(random_sample());
  endtask

  // Receiver: random stall patterns, plus long hold-offs on request.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else if (hold_served != hold_requests) begin
      hold_served++;
      hold_left = LONG_HOLD - 1;
      out_ready_i <= 1'b0;
    end else begin
      if (stall_left == 0) begin
        stall_kind = rx_pattern_e'($urandom_range(0, 3));
        stall_left = $urandom_range(10, 150);
      end
      stall_left--;
      case (stall_kind)
        RX_OPEN: out_ready_i <= 1'b1;
        RX_COIN: out_ready_i <= ($urandom_range(0, 1) == 0);
        RX_SPARSE: out_ready_i <= ($urandom_range(0, 4) == 0);
        default: out_ready_i <= ((stall_left % 16) < 4);
      endcase
    end
  end

  // Compare every accepted result item with the oldest expectation.
  always @(posedge clk_i) begin : check_results
    bank_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_outputs.size() == 0) begin
        report_mismatch($sformatf("unexpected result item sample_out=%h", sample_out_o));
      end else begin
        want = expected_outputs.pop_front();
        if (sample_out_o !== want.sample) begin
          report_mismatch($sformatf("sample_out got %h want %h", sample_out_o, want.sample));
        end
        if (saturated_o !== want.clip) begin
          report_mismatch($sformatf("saturated got %b want %b", saturated_o, want.clip));
        end
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_silent_bank();
    test_directed_extremes();
    test_mode_count_range();
    test_backpressure();
    test_random_bank();
    test_drain_pause();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog well beyond the slowest legal run.
  initial begin
    #15_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
